// ----- rtl/qse_pkg.sv -----
// ============================================================================
// qse_pkg: shared types for the quicksort engine
// Transfer payloads of both channels and the range stack command group.
// ============================================================================
package qse_pkg;

    localparam int VALUE_W = 32;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic                      is_last;
    } item_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0] sorted_value;
        logic                      end_of_run;
        logic                      overflowed;
    } result_t;

    typedef struct packed {
        logic push;
        logic pop;
    } stk_cmd_t;

endpackage

// ----- rtl/qse_store.sv -----
// ============================================================================
// qse_store: element store with the shared key comparator
// One write port, one registered read port; the read word is compared
// against the pivot (signed, strict less-than).
// ============================================================================
module qse_store
    import qse_pkg::*;
#(
    parameter int ARRAY_DEPTH = 64
)
(
    input  logic                              clk,
    input  logic                              we,
    input  logic [$clog2(ARRAY_DEPTH)-1:0]    waddr,
    input  logic [VALUE_W-1:0]                wdata,
    input  logic                              re,
    input  logic [$clog2(ARRAY_DEPTH)-1:0]    raddr,
    input  logic [VALUE_W-1:0]                pivot,
    output logic [VALUE_W-1:0]                rdata,
    output logic                              less
);

    logic [VALUE_W-1:0] mem [ARRAY_DEPTH];
    logic [VALUE_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;
    assign less  = $signed(rdata_reg) < $signed(pivot);

endmodule

// ----- rtl/qse_stack.sv -----
// ============================================================================
// qse_stack: range stack for the partition sequencer
// Holds {lo, hi} pairs; pop loads the top entry into a register. A push on a
// full stack is ignored.
// ============================================================================
module qse_stack
    import qse_pkg::*;
#(
    parameter int ARRAY_DEPTH = 64
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  stk_cmd_t                            cmd,
    input  logic [2*$clog2(ARRAY_DEPTH)-1:0]    push_entry,
    output logic [2*$clog2(ARRAY_DEPTH)-1:0]    top_entry,
    output logic                                empty
);

    localparam int IW = $clog2(ARRAY_DEPTH);
    localparam int CW = $clog2(ARRAY_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(ARRAY_DEPTH);

    logic [2*IW-1:0] mem [ARRAY_DEPTH];
    logic [2*IW-1:0] top_reg;
    logic [CW-1:0]   sp_reg;
    logic [CW-1:0]   sp_m1;

    assign sp_m1 = sp_reg - CW'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sp_reg <= '0;
        end
        else if (cmd.push && (sp_reg != DEPTH_C))
        begin
            sp_reg <= sp_reg + CW'(1);
        end
        else if (cmd.pop && (sp_reg != '0))
        begin
            sp_reg <= sp_m1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.push && (sp_reg != DEPTH_C))
        begin
            mem[sp_reg[IW-1:0]] <= push_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.pop)
        begin
            top_reg <= mem[sp_m1[IW-1:0]];
        end
    end

    assign top_entry = top_reg;
    assign empty     = (sp_reg == '0);

endmodule

// ----- rtl/quicksort_engine.sv -----
// ============================================================================
// quicksort_engine: buffered in-place quicksort of signed 32-bit values
// Loads a set into the element store, sorts it with a pivot-hopping
// partition driven by a range stack, then streams it out in ascending order.
// ============================================================================
// Load: one input transfer per cycle; item_stall stays low while loading.
// Sort: each scan step issues a read, then compares; a pivot hop adds a
//   pivot write; every read uses the single read port of the element store.
// Emit: per result, store read, then output register load (held while
//   the consumer stalls). Next set loads once the last result is registered.
// Reset: control state, counters and stack pointer clear; store contents stay.
module quicksort_engine
    import qse_pkg::*;
#(
    parameter int ARRAY_DEPTH = 64
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    item_valid,
    output logic    item_stall,
    input  item_t   item,
    output logic    result_valid,
    input  logic    result_stall,
    output result_t result
);

    localparam int IW = $clog2(ARRAY_DEPTH);
    localparam int CW = $clog2(ARRAY_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(ARRAY_DEPTH);

    // sequencer states
    localparam logic [3:0] S_LOAD  = 4'd0;   // accepting items
    localparam logic [3:0] S_POP   = 4'd1;   // pop next range, or finish
    localparam logic [3:0] S_POPW  = 4'd2;   // range in hand, fetch pivot
    localparam logic [3:0] S_PIVW  = 4'd3;   // latch pivot
    localparam logic [3:0] S_A     = 4'd4;   // right scan: issue read of r
    localparam logic [3:0] S_AW    = 4'd5;   // right scan: compare
    localparam logic [3:0] S_AX    = 4'd6;   // right hop: pivot to new spot
    localparam logic [3:0] S_B     = 4'd7;   // left scan: issue read of l
    localparam logic [3:0] S_BW    = 4'd8;   // left scan: compare
    localparam logic [3:0] S_BX    = 4'd9;   // left hop: pivot to new spot
    localparam logic [3:0] S_PUSH1 = 4'd10;  // push right part
    localparam logic [3:0] S_PUSH2 = 4'd11;  // push left part
    localparam logic [3:0] S_ERD   = 4'd12;  // emit: read element
    localparam logic [3:0] S_EOUT  = 4'd13;  // emit: load output register

    logic [3:0]          state_reg, state_next;
    logic [CW-1:0]       count_reg, count_next;
    logic [CW-1:0]       cnt_m1;
    logic                ovf_reg, ovf_next;
    logic [IW-1:0]       lo_reg, lo_next;
    logic [IW-1:0]       hi_reg, hi_next;
    logic [IW-1:0]       l_reg, l_next;
    logic [IW-1:0]       r_reg, r_next;
    logic [IW-1:0]       p_reg, p_next;
    logic [IW-1:0]       idx_reg, idx_next;
    logic [VALUE_W-1:0]  pivot_reg, pivot_next;
    logic                out_valid_reg, out_valid_next;
    result_t             out_reg, out_next;

    // element store port
    logic                st_we, st_re, st_less;
    logic [IW-1:0]       st_waddr, st_raddr;
    logic [VALUE_W-1:0]  st_wdata, st_rdata;

    // range stack port
    stk_cmd_t            stk_cmd;
    logic [2*IW-1:0]     stk_push, stk_top;
    logic                stk_empty;

    logic                accept;
    logic                last_idx;

    qse_store #(.ARRAY_DEPTH(ARRAY_DEPTH)) u_store (
        .clk   (clk),
        .we    (st_we),
        .waddr (st_waddr),
        .wdata (st_wdata),
        .re    (st_re),
        .raddr (st_raddr),
        .pivot (pivot_reg),
        .rdata (st_rdata),
        .less  (st_less)
    );

    qse_stack #(.ARRAY_DEPTH(ARRAY_DEPTH)) u_stack (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (stk_cmd),
        .push_entry (stk_push),
        .top_entry  (stk_top),
        .empty      (stk_empty)
    );

    assign item_stall = (state_reg != S_LOAD);
    assign accept     = item_valid && !item_stall;
    assign last_idx   = ({{(CW-IW){1'b0}}, idx_reg} == (count_reg - CW'(1)));

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        ovf_next       = ovf_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        l_next         = l_reg;
        r_next         = r_reg;
        p_next         = p_reg;
        idx_next       = idx_reg;
        pivot_next     = pivot_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && result_stall;
        st_we          = 1'b0;
        st_waddr       = p_reg;
        st_wdata       = st_rdata;
        st_re          = 1'b0;
        st_raddr       = r_reg;
        stk_cmd        = '0;
        stk_push       = {lo_reg, hi_reg};
        cnt_m1         = '0;

        unique case (state_reg)
            S_LOAD:
            begin
                if (accept)
                begin
                    if (count_reg != DEPTH_C)
                    begin
                        st_we      = 1'b1;
                        st_waddr   = count_reg[IW-1:0];
                        st_wdata   = item.value;
                        count_next = count_reg + CW'(1);
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    cnt_m1 = count_next - CW'(1);
                    if (item.is_last)
                    begin
                        idx_next = '0;
                        if (count_next < CW'(2))
                        begin
                            state_next = S_ERD;
                        end
                        else
                        begin
                            // whole set is the first range
                            stk_cmd.push = 1'b1;
                            stk_push     = {{IW{1'b0}}, cnt_m1[IW-1:0]};
                            state_next   = S_POP;
                        end
                    end
                end
            end

            S_POP:
            begin
                if (stk_empty)
                begin
                    idx_next   = '0;
                    state_next = S_ERD;
                end
                else
                begin
                    stk_cmd.pop = 1'b1;
                    state_next  = S_POPW;
                end
            end

            S_POPW:
            begin
                lo_next = stk_top[2*IW-1:IW];
                hi_next = stk_top[IW-1:0];
                l_next  = stk_top[2*IW-1:IW];
                r_next  = stk_top[IW-1:0];
                p_next  = stk_top[2*IW-1:IW];
                if (stk_top[2*IW-1:IW] < stk_top[IW-1:0])
                begin
                    st_re      = 1'b1;
                    st_raddr   = stk_top[2*IW-1:IW];
                    state_next = S_PIVW;
                end
                else
                begin
                    state_next = S_POP;
                end
            end

            S_PIVW:
            begin
                pivot_next = st_rdata;
                state_next = S_A;
            end

            S_A:
            begin
                if (p_reg != r_reg)
                begin
                    st_re      = 1'b1;
                    st_raddr   = r_reg;
                    state_next = S_AW;
                end
                else if (r_reg == l_reg)
                begin
                    state_next = S_PUSH1;
                end
                else
                begin
                    state_next = S_B;
                end
            end

            S_AW:
            begin
                if (st_less)
                begin
                    // smaller key hops left of the pivot
                    st_we      = 1'b1;
                    st_waddr   = p_reg;
                    st_wdata   = st_rdata;
                    p_next     = r_reg;
                    state_next = S_AX;
                end
                else
                begin
                    r_next     = r_reg - IW'(1);
                    state_next = S_A;
                end
            end

            S_AX:
            begin
                st_we    = 1'b1;
                st_waddr = r_reg;
                st_wdata = pivot_reg;
                if (r_reg == l_reg)
                begin
                    state_next = S_PUSH1;
                end
                else
                begin
                    state_next = S_B;
                end
            end

            S_B:
            begin
                if (l_reg != p_reg)
                begin
                    st_re      = 1'b1;
                    st_raddr   = l_reg;
                    state_next = S_BW;
                end
                else if (l_reg == r_reg)
                begin
                    state_next = S_PUSH1;
                end
                else
                begin
                    state_next = S_A;
                end
            end

            S_BW:
            begin
                if (!st_less)
                begin
                    // key not below pivot hops right of it
                    st_we      = 1'b1;
                    st_waddr   = p_reg;
                    st_wdata   = st_rdata;
                    p_next     = l_reg;
                    state_next = S_BX;
                end
                else
                begin
                    l_next     = l_reg + IW'(1);
                    state_next = S_B;
                end
            end

            S_BX:
            begin
                st_we    = 1'b1;
                st_waddr = l_reg;
                st_wdata = pivot_reg;
                if (l_reg == r_reg)
                begin
                    state_next = S_PUSH1;
                end
                else
                begin
                    state_next = S_A;
                end
            end

            S_PUSH1:
            begin
                // right part only when it holds two or more elements
                if (({1'b0, p_reg} + (IW+1)'(1)) < {1'b0, hi_reg})
                begin
                    stk_cmd.push = 1'b1;
                    stk_push     = {p_reg + IW'(1), hi_reg};
                end
                state_next = S_PUSH2;
            end

            S_PUSH2:
            begin
                if (({1'b0, lo_reg} + (IW+1)'(1)) < {1'b0, p_reg})
                begin
                    stk_cmd.push = 1'b1;
                    stk_push     = {lo_reg, p_reg - IW'(1)};
                end
                state_next = S_POP;
            end

            S_ERD:
            begin
                st_re      = 1'b1;
                st_raddr   = idx_reg;
                state_next = S_EOUT;
            end

            S_EOUT:
            begin
                if (!out_valid_reg || !result_stall)
                begin
                    out_valid_next        = 1'b1;
                    out_next.sorted_value = st_rdata;
                    out_next.end_of_run   = last_idx;
                    out_next.overflowed   = ovf_reg;
                    if (last_idx)
                    begin
                        count_next = '0;
                        ovf_next   = 1'b0;
                        state_next = S_LOAD;
                    end
                    else
                    begin
                        idx_next   = idx_reg + IW'(1);
                        state_next = S_ERD;
                    end
                end
            end

            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_LOAD;
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            ovf_reg       <= ovf_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // datapath registers, no reset needed
    always_ff @(posedge clk)
    begin
        lo_reg    <= lo_next;
        hi_reg    <= hi_next;
        l_reg     <= l_next;
        r_reg     <= r_next;
        p_reg     <= p_next;
        idx_reg   <= idx_next;
        pivot_reg <= pivot_next;
        out_reg   <= out_next;
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    // pivot always sits at one end of the unscanned window
    a_pivot_at_edge: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_A || state_reg == S_AW || state_reg == S_AX ||
         state_reg == S_B || state_reg == S_BW || state_reg == S_BX)
        |-> (p_reg == l_reg || p_reg == r_reg))
        else $error("pivot left the scan window");

    // scan pointers never cross
    a_no_cross: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_A || state_reg == S_AW || state_reg == S_AX ||
         state_reg == S_B || state_reg == S_BW || state_reg == S_BX)
        |-> (l_reg <= r_reg))
        else $error("scan pointers crossed");

    // emitting always has at least one stored element
    a_emit_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ERD || state_reg == S_EOUT)
        |-> (count_reg != '0 && count_reg <= DEPTH_C))
        else $error("emit with bad element count");

endmodule
